FILE: hw/rtl/lba_pkg.sv
// Shared types and constants for the linked block allocator.
`default_nettype none
package lba_pkg;

  localparam int NUM_BLOCKS = 64;
  localparam int NUM_FILES  = 16;

  // Field widths of the transfer payloads
  localparam int CMD_W      = 1;
  localparam int COUNT_W    = 7;
  localparam int FILE_W     = 4;
  localparam int STATUS_W   = 2;
  localparam int BLOCK_ID_W = 6;

  // Internal widths
  localparam int BIDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int LINK_W = $clog2(NUM_BLOCKS + 1);
  localparam int FIDX_W = (NUM_FILES > 1) ? $clog2(NUM_FILES) : 1;
  localparam int FCNT_W = $clog2(NUM_FILES + 1);

  localparam logic [LINK_W-1:0] LINK_END = LINK_W'(NUM_BLOCKS);

  localparam logic [CMD_W-1:0] CMD_ALLOC = 1'b0;
  localparam logic [CMD_W-1:0] CMD_LIST  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOSPACE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOFILE  = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [COUNT_W-1:0] block_count;
    logic [FILE_W-1:0]  file_index;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic [FILE_W-1:0]     file_slot;
    logic [BLOCK_ID_W-1:0] block_id;
    logic                  has_block;
    logic                  last;
  } out_item_t;

  // Classified command as it waits in the queue
  typedef struct packed {
    logic               is_list;
    logic [COUNT_W-1:0] block_count;
    logic [FILE_W-1:0]  file_index;
  } op_t;

  // Front to back handoff
  typedef struct packed {
    logic valid;
    op_t  op;
  } op_chan_t;

endpackage
`default_nettype wire

FILE: hw/rtl/lba_front.sv
// Front end: accepts commands, decodes them and queues them for the back end.
`default_nettype none
module lba_front
  import lba_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_item_t in_data,
  output op_chan_t      op_chan,
  input  wire logic     op_pop
);

  localparam int DEPTH = 2;

  op_t        queue_r [DEPTH];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  logic       pop;
  op_t        op_in;

  assign in_stall = (cnt_r == 2'(DEPTH));
  assign push     = in_valid && !in_stall;
  assign pop      = op_pop && (cnt_r != 2'd0);

  always_comb begin
    op_in.is_list     = (in_data.cmd == CMD_LIST);
    op_in.block_count = in_data.block_count;
    op_in.file_index  = in_data.file_index;
  end

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue_r[wr_ptr_r] <= op_in;
    end
  end

  assign op_chan.valid = (cnt_r != 2'd0);
  assign op_chan.op    = queue_r[rd_ptr_r];

endmodule
`default_nettype wire

FILE: hw/rtl/lba_back.sv
// Back end: block pool, link and file tables, allocate scan and chain walk.
`default_nettype none
module lba_back
  import lba_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire op_chan_t  op_chan,
  output logic           op_pop,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_FIN,
    S_LSTART,
    S_LWALK
  } state_t;

  state_t              state_r, state_nxt;
  logic [NUM_BLOCKS-1:0] used_r, used_nxt;
  logic [FCNT_W-1:0]   files_r, files_nxt;
  logic [LINK_W-1:0]   free_r, free_nxt;
  logic [COUNT_W-1:0]  count_r, count_nxt;
  logic [LINK_W-1:0]   taken_r, taken_nxt;
  logic [BIDX_W-1:0]   scan_r, scan_nxt;
  logic [LINK_W-1:0]   head_r, head_nxt;
  logic [BIDX_W-1:0]   tail_r, tail_nxt;
  logic [BIDX_W-1:0]   cur_r, cur_nxt;
  logic [BIDX_W-1:0]   n_r, n_nxt;
  logic [FILE_W-1:0]   idx_r, idx_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_data_r, out_data_nxt;

  logic [LINK_W-1:0]   nl_mem [NUM_BLOCKS];
  logic [LINK_W-1:0]   cs_mem [NUM_FILES];
  logic [LINK_W-1:0]   nl_rdata;
  logic [LINK_W-1:0]   cs_rdata;
  logic                nl_we, nl_re, cs_we, cs_re;
  logic [BIDX_W-1:0]   nl_waddr, nl_raddr;
  logic [LINK_W-1:0]   nl_wdata;
  logic [FIDX_W-1:0]   cs_waddr, cs_raddr;
  logic [LINK_W-1:0]   cs_wdata;

  logic                out_free;
  logic                out_ld;
  out_item_t           out_item;
  logic                walk_last;
  op_t                 op;

  assign op       = op_chan.op;
  assign out_free = !out_valid_r || !out_stall;
  assign walk_last = (nl_rdata >= LINK_END) || (n_r == BIDX_W'(NUM_BLOCKS - 1));

  always_comb begin
    state_nxt = state_r;
    used_nxt  = used_r;
    files_nxt = files_r;
    free_nxt  = free_r;
    count_nxt = count_r;
    taken_nxt = taken_r;
    scan_nxt  = scan_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    cur_nxt   = cur_r;
    n_nxt     = n_r;
    idx_nxt   = idx_r;
    op_pop    = 1'b0;
    nl_we     = 1'b0;
    nl_waddr  = tail_r;
    nl_wdata  = LINK_END;
    nl_re     = 1'b0;
    nl_raddr  = cur_r;
    cs_we     = 1'b0;
    cs_waddr  = files_r[FIDX_W-1:0];
    cs_wdata  = head_r;
    cs_re     = 1'b0;
    cs_raddr  = FIDX_W'(op.file_index);
    out_ld    = 1'b0;
    out_item  = '0;
    out_item.last = 1'b1;

    case (state_r)
      S_IDLE: begin
        if (op_chan.valid) begin
          if (!op.is_list) begin
            if (LINK_W'(op.block_count) > free_r) begin
              if (out_free) begin
                out_ld          = 1'b1;
                out_item.status = ST_NOSPACE;
                op_pop          = 1'b1;
              end
            end else if (files_r >= FCNT_W'(NUM_FILES)) begin
              if (out_free) begin
                out_ld          = 1'b1;
                out_item.status = ST_FULL;
                op_pop          = 1'b1;
              end
            end else begin
              op_pop    = 1'b1;
              count_nxt = op.block_count;
              taken_nxt = '0;
              scan_nxt  = '0;
              head_nxt  = LINK_END;
              state_nxt = S_SCAN;
            end
          end else begin
            if (FCNT_W'(op.file_index) >= files_r) begin
              if (out_free) begin
                out_ld             = 1'b1;
                out_item.status    = ST_NOFILE;
                out_item.file_slot = op.file_index;
                op_pop             = 1'b1;
              end
            end else begin
              op_pop    = 1'b1;
              cs_re     = 1'b1;
              idx_nxt   = op.file_index;
              state_nxt = S_LSTART;
            end
          end
        end
      end

      S_SCAN: begin
        if (taken_r == LINK_W'(count_r)) begin
          state_nxt = S_FIN;
        end else begin
          if (!used_r[scan_r]) begin
            used_nxt[scan_r] = 1'b1;
            if (head_r == LINK_END) begin
              head_nxt = LINK_W'(scan_r);
            end else begin
              nl_we    = 1'b1;
              nl_waddr = tail_r;
              nl_wdata = LINK_W'(scan_r);
            end
            tail_nxt  = scan_r;
            taken_nxt = taken_r + LINK_W'(1);
          end
          scan_nxt = scan_r + BIDX_W'(1);
        end
      end

      S_FIN: begin
        if (out_free) begin
          nl_we    = (head_r != LINK_END);
          nl_waddr = tail_r;
          nl_wdata = LINK_END;
          cs_we    = 1'b1;
          cs_waddr = files_r[FIDX_W-1:0];
          cs_wdata = head_r;
          files_nxt = files_r + FCNT_W'(1);
          free_nxt  = free_r - taken_r;
          out_ld             = 1'b1;
          out_item.status    = ST_OK;
          out_item.file_slot = FILE_W'(files_r);
          if (head_r != LINK_END) begin
            out_item.block_id  = BLOCK_ID_W'(head_r);
            out_item.has_block = 1'b1;
          end
          state_nxt = S_IDLE;
        end
      end

      S_LSTART: begin
        if (cs_rdata >= LINK_END) begin
          if (out_free) begin
            out_ld             = 1'b1;
            out_item.status    = ST_OK;
            out_item.file_slot = idx_r;
            state_nxt          = S_IDLE;
          end
        end else begin
          nl_re     = 1'b1;
          nl_raddr  = cs_rdata[BIDX_W-1:0];
          cur_nxt   = cs_rdata[BIDX_W-1:0];
          n_nxt     = '0;
          state_nxt = S_LWALK;
        end
      end

      S_LWALK: begin
        if (out_free) begin
          out_ld             = 1'b1;
          out_item.status    = ST_OK;
          out_item.file_slot = idx_r;
          out_item.block_id  = BLOCK_ID_W'(cur_r);
          out_item.has_block = 1'b1;
          out_item.last      = walk_last;
          if (walk_last) begin
            state_nxt = S_IDLE;
          end else begin
            nl_re    = 1'b1;
            nl_raddr = nl_rdata[BIDX_W-1:0];
            cur_nxt  = nl_rdata[BIDX_W-1:0];
            n_nxt    = n_r + BIDX_W'(1);
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_data_nxt  = out_ld ? out_item : out_data_r;
    out_valid_nxt = out_ld || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      files_r     <= '0;
      free_r      <= LINK_W'(NUM_BLOCKS);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      files_r     <= files_nxt;
      free_r      <= free_nxt;
      out_valid_r <= out_valid_nxt;
    end
    count_r    <= count_nxt;
    taken_r    <= taken_nxt;
    scan_r     <= scan_nxt;
    head_r     <= head_nxt;
    tail_r     <= tail_nxt;
    cur_r      <= cur_nxt;
    n_r        <= n_nxt;
    idx_r      <= idx_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (nl_we) begin
      nl_mem[nl_waddr] <= nl_wdata;
    end
    if (nl_re) begin
      nl_rdata <= nl_mem[nl_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cs_we) begin
      cs_mem[cs_waddr] <= cs_wdata;
    end
    if (cs_re) begin
      cs_rdata <= cs_mem[cs_raddr];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

FILE: hw/rtl/linked_block_allocator.sv
// Top level of the linked block allocator: command queue front, allocator back.
//
//   port group   dir  payload     role
//   in_*         in   in_item_t   command transfer (allocate / list)
//   out_*        out  out_item_t  result transfer, one or more per command
//
// Allocate: S_IDLE takes the command, S_SCAN tests one pool block per cycle
// until the request is met (up to NUM_BLOCKS) and then sees the count reached,
// and S_FIN commits and posts the result. Errors post straight from S_IDLE.
// List: S_IDLE and S_LSTART fetch the chain head, then one result per block.
// Synchronous active-low reset frees every block and empties the file table.
// A two-entry queue takes commands while a result waits; out_stall holds the walk.
`default_nettype none
module linked_block_allocator
  import lba_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);

  op_chan_t op_chan;
  logic     op_pop;

  lba_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .op_chan  (op_chan),
    .op_pop   (op_pop)
  );

  lba_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .op_chan   (op_chan),
    .op_pop    (op_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
